// ----- hw/rtl/lfde_pkg.sv -----
`default_nettype none

package lfde_pkg;

  // Widths fixed by the item formats
  localparam int POS_W   = 8;
  localparam int COLOR_W = 24;
  localparam int WORD_W  = 32;

  // Default frame capacity
  localparam int MAX_LEDS_DEF = 255;

  // Input item modes
  localparam logic [1:0] MODE_PIXEL   = 2'd0;
  localparam logic [1:0] MODE_PING    = 2'd1;
  localparam logic [1:0] MODE_ENABLE  = 2'd2;
  localparam logic [1:0] MODE_DISABLE = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_COLOR  = 2'd0;
  localparam logic [1:0] KIND_MARKER = 2'd1;
  localparam logic [1:0] KIND_PONG   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } lfde_in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [WORD_W-1:0] color_word;
    logic              last;
  } lfde_out_t;

  // Decoded item held between the front end and the result stage
  typedef struct packed {
    logic               px;         // pixel that compares and writes the store
    logic [POS_W-1:0]   pos;
    logic [COLOR_W-1:0] color;
    logic               is_ref;     // position matches refresh index
    logic               has_term;   // marker, error or pong follows
    logic [1:0]         term_kind;
    logic               prior_vld;  // entry written since reset
    logic               byp;        // entry written on the read edge
    logic [COLOR_W-1:0] byp_data;
  } lfde_stage_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lfde_ram.sv -----
`default_nettype none

module lfde_ram #(
  parameter int WIDTH  = 24,
  parameter int DEPTH  = 255,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lfde_ctrl.sv -----
`default_nettype none

module lfde_ctrl
  import lfde_pkg::*;
#(
  parameter int MAX_LEDS = MAX_LEDS_DEF,
  parameter int ADDR_W   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lfde_in_t            in_data,
  input  wire logic                s1_adv,
  output logic                     s1_valid,
  output lfde_stage_t              s1,
  output logic                     ram_we,
  output logic      [ADDR_W-1:0]   ram_waddr,
  output logic      [COLOR_W-1:0]  ram_wdata,
  output logic                     ram_re,
  output logic      [ADDR_W-1:0]   ram_raddr
);

  logic             s1_valid_r, s1_valid_nxt;
  lfde_stage_t      s1_r, s1_nxt;
  logic             en_r, en_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] ref_r, ref_nxt;
  logic             ovf_r, ovf_nxt;
  logic [MAX_LEDS-1:0] written_r;
  logic             accept;
  logic             load;
  logic             wr_hit;

  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  // Store write of the departing pixel lands on the same edge as this read
  assign wr_hit = s1_adv && s1_r.px && (s1_r.pos == pos_r);

  // Frame state and decode of the accepted item
  always_comb begin
    logic             ovf_v;
    logic [POS_W:0]   size_v;
    logic [POS_W:0]   next_v;
    ovf_v   = ovf_r;
    size_v  = '0;
    next_v  = '0;
    en_nxt  = en_r;
    pos_nxt = pos_r;
    ref_nxt = ref_r;
    ovf_nxt = ovf_r;
    load    = 1'b0;
    s1_nxt           = s1_r;
    s1_nxt.px        = 1'b0;
    s1_nxt.pos       = pos_r;
    s1_nxt.color     = {in_data.red, in_data.green, in_data.blue};
    s1_nxt.is_ref    = (pos_r == ref_r);
    s1_nxt.has_term  = 1'b0;
    s1_nxt.term_kind = KIND_MARKER;
    s1_nxt.prior_vld = 1'b0;
    s1_nxt.byp       = wr_hit;
    s1_nxt.byp_data  = s1_r.color;
    if (accept) begin
      unique case (in_data.mode) inside
        MODE_PING: begin
          load             = 1'b1;
          s1_nxt.has_term  = 1'b1;
          s1_nxt.term_kind = KIND_PONG;
        end
        MODE_ENABLE, MODE_DISABLE: begin
          en_nxt  = (in_data.mode == MODE_ENABLE);
          pos_nxt = '0;
          ovf_nxt = 1'b0;
        end
        MODE_PIXEL: begin
          if (en_r) begin
            if (pos_r >= POS_W'(MAX_LEDS)) begin
              ovf_v = 1'b1;
            end else begin
              s1_nxt.px        = 1'b1;
              s1_nxt.prior_vld = written_r[pos_r[ADDR_W-1:0]];
              pos_nxt          = pos_r + 1'b1;
            end
            ovf_nxt = ovf_v;
            load    = s1_nxt.px;
            if (in_data.frame_end) begin
              load            = 1'b1;
              s1_nxt.has_term = 1'b1;
              if (ovf_v) begin
                s1_nxt.term_kind = KIND_ERROR;
              end else begin
                size_v  = {1'b0, pos_nxt};
                next_v  = {1'b0, ref_r} + 1'b1;
                ref_nxt = (next_v >= size_v) ? '0 : next_v[POS_W-1:0];
              end
              pos_nxt = '0;
              ovf_nxt = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Stage occupancy
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      en_r       <= 1'b0;
      pos_r      <= '0;
      ref_r      <= '0;
      ovf_r      <= 1'b0;
      written_r  <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      en_r       <= en_nxt;
      pos_r      <= pos_nxt;
      ref_r      <= ref_nxt;
      ovf_r      <= ovf_nxt;
      if (ram_we) begin
        written_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_r <= s1_nxt;
    end
  end

  // Store ports: read at the frame position, write as the pixel leaves
  assign ram_re    = accept;
  assign ram_raddr = pos_r[ADDR_W-1:0];
  assign ram_we    = s1_adv && s1_r.px;
  assign ram_waddr = s1_r.pos[ADDR_W-1:0];
  assign ram_wdata = s1_r.color;

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

`default_nettype wire

// ----- hw/rtl/lfde_emit.sv -----
`default_nettype none

module lfde_emit
  import lfde_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               s1_valid,
  input  wire lfde_stage_t        s1,
  input  wire logic [COLOR_W-1:0] rdata,
  output logic                    s1_adv,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output lfde_out_t               out_data
);

  lfde_out_t    slot0_r, slot0_nxt;
  lfde_out_t    slot1_r, slot1_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic [COLOR_W-1:0] prior;
  logic         changed;
  logic         take;
  lfde_out_t    res_color, res_term, res_a, res_b;
  logic [1:0]   res_n;

  assign take   = out_valid && !out_stall;
  assign s1_adv = s1_valid && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && take));

  // Prior color: forwarded, stored, or the reset value
  assign prior   = s1.byp ? s1.byp_data : (s1.prior_vld ? rdata : '0);
  assign changed = s1.px && ((prior != s1.color) || s1.is_ref);

  // Results of the staged item, in order
  always_comb begin
    res_color.kind       = KIND_COLOR;
    res_color.color_word = {s1.color, s1.pos};
    res_color.last       = !s1.has_term;
    res_term.kind        = s1.term_kind;
    res_term.color_word  = '0;
    res_term.last        = 1'b1;
    res_a = changed ? res_color : res_term;
    res_b = res_term;
    res_n = {1'b0, changed} + {1'b0, s1.has_term};
  end

  // Two-entry result buffer
  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (s1_adv) begin
      slot0_nxt = res_a;
      slot1_nxt = res_b;
      cnt_nxt   = res_n;
    end else if (take) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> (!slot0_r.last && slot1_r.last))
    else $error("result pair not ordered with last on the second");

  a_pair_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (cnt_r == 2'd2)) |=> out_valid)
    else $error("second result of a pair lost");

endmodule

`default_nettype wire

// ----- hw/rtl/led_frame_delta_encoder.sv -----
`default_nettype none

// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  lfde_in_t  {mode, red, green, blue, frame_end}
// out_     output     out_valid/out_stall lfde_out_t {kind, color_word, last}
//
// One item per cycle is accepted while in_stall is low; a result is registered in
// the decode stage and then in the result buffer before it is valid at out_,
// with the store read running alongside the decode stage.
// An item that gives two results holds the input while
// the two-entry result buffer drains.
// Synchronous active-low reset; the color store reads as zero until each
// entry is first written (per-entry written flags), so no clearing pass runs.
// A stall on out_ backs up through the single decode stage to in_stall.

module led_frame_delta_encoder
  import lfde_pkg::*;
#(
  parameter int MAX_LEDS = MAX_LEDS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire lfde_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output lfde_out_t      out_data
);

  localparam int ADDR_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  logic               s1_adv;
  logic               s1_valid;
  lfde_stage_t        s1;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [COLOR_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [COLOR_W-1:0] ram_rdata;

  lfde_ctrl #(
    .MAX_LEDS (MAX_LEDS),
    .ADDR_W   (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .s1_adv    (s1_adv),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  lfde_ram #(
    .WIDTH  (COLOR_W),
    .DEPTH  (MAX_LEDS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lfde_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .rdata     (ram_rdata),
    .s1_adv    (s1_adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- sim/tb_led_frame_delta_encoder.sv -----
`default_nettype none

module tb_led_frame_delta_encoder;
  import lfde_pkg::*;

  localparam int ITEM_TARGET = 950;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;

  // Tracks the color store, frame position and refresh index,
  // and keeps the color words, markers, pongs and errors still owed by the block.
  class frame_delta_model;
    logic [COLOR_W-1:0] prior [MAX_LEDS_DEF];
    int                 next_pos;
    int                 refresh;
    bit                 enabled;
    bit                 overflow;
    lfde_out_t          pending_words [$];
    int                 errors;

    function new();
      foreach (prior[i]) prior[i] = '0;
      next_pos = 0;
      refresh  = 0;
      enabled  = 1'b0;
      overflow = 1'b0;
      errors   = 0;
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function void owe(logic [1:0] kind, logic [WORD_W-1:0] word, logic last);
      lfde_out_t r;
      r.kind       = kind;
      r.color_word = word;
      r.last       = last;
      pending_words.push_back(r);
    endfunction

    // Work out the results of one accepted input transfer
    function void note_transfer(lfde_in_t item);
      logic [COLOR_W-1:0] color;
      int                 adv;
      color = {item.red, item.green, item.blue};
      case (item.mode)
        MODE_PING: owe(KIND_PONG, '0, 1'b1);
        MODE_ENABLE, MODE_DISABLE: begin
          enabled  = (item.mode == MODE_ENABLE);
          next_pos = 0;
          overflow = 1'b0;
        end
        default: begin
          if (enabled) begin
            if (next_pos >= MAX_LEDS_DEF) begin
              overflow = 1'b1;
            end else begin
              if (prior[next_pos] != color || next_pos == refresh)
                owe(KIND_COLOR, {color, next_pos[POS_W-1:0]}, !item.frame_end);
              prior[next_pos] = color;
              next_pos++;
            end
            if (item.frame_end) begin
              if (overflow) begin
                owe(KIND_ERROR, '0, 1'b1);
              end else begin
                adv = refresh + 1;
                refresh = (adv >= next_pos) ? 0 : adv;
                owe(KIND_MARKER, '0, 1'b1);
              end
              next_pos = 0;
              overflow = 1'b0;
            end
          end
        end
      endcase
    endfunction

    // Compare one accepted result with the oldest one owed
    task check_result(lfde_out_t got);
      lfde_out_t want;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected result kind %0d word %h", got.kind, got.color_word));
        return;
      end
      want = pending_words.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.color_word !== want.color_word)
        report($sformatf("word %h, expected %h", got.color_word, want.color_word));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b", got.last, want.last));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  lfde_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  lfde_out_t out_data;

  frame_delta_model model;
  bit               in_xfer;
  bit               hold_req;
  bit               hold_done;
  int               effective;
  int               burst_left;
  int               cycles;

  led_frame_delta_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample both channels mid-cycle; a transfer seen here completes at the next rising edge
  always @(negedge clk) begin
    in_xfer = rst_n && in_valid && (in_stall === 1'b0);
    if (in_xfer) model.note_transfer(in_data);
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) model.check_result(out_data);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: stall phases of random density, plus one long hold-off on request
  initial begin
    int span;
    int pct;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      span = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0:       pct = 0;
        1:       pct = 20;
        2:       pct = 50;
        default: pct = 85;
      endcase
      repeat (span) begin
        @(posedge clk);
        if (hold_req && !hold_done) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_done = 1'b1;
        end
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  function automatic lfde_in_t pixel(logic [COLOR_W-1:0] color, logic fend);
    lfde_in_t item;
    item.mode      = MODE_PIXEL;
    {item.red, item.green, item.blue} = color;
    item.frame_end = fend;
    return item;
  endfunction

  // Control item with junk in the color and frame-end fields
  function automatic lfde_in_t control(logic [1:0] mode);
    lfde_in_t item;
    item      = lfde_in_t'(27'($urandom));
    item.mode = mode;
    return item;
  endfunction

  // Half the time repeat the stored color so unchanged pixels occur
  function automatic logic [COLOR_W-1:0] next_color();
    logic [COLOR_W-1:0] c;
    if (model.next_pos < MAX_LEDS_DEF && $urandom_range(0, 1) == 0)
      return model.prior[model.next_pos];
    c = COLOR_W'($urandom);
    if ($urandom_range(0, 5) == 0) c[23:16] = {8{c[0]}};
    if ($urandom_range(0, 5) == 0) c[15:8]  = {8{c[1]}};
    if ($urandom_range(0, 5) == 0) c[7:0]   = {8{c[2]}};
    return c;
  endfunction

  // Offer one item in bursts with random gaps; returns at the edge of its transfer
  task automatic offer(lfde_in_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        in_data  <= lfde_in_t'(27'($urandom));
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    if (!(item.mode == MODE_PIXEL && !model.enabled)) effective++;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_xfer);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (model.pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Pixels of one frame; an unterminated frame just runs into the next items
  task automatic send_frame(int len, bit terminate);
    for (int i = 0; i < len; i++)
      offer(pixel(next_color(), terminate && (i == len - 1)));
  endtask

  initial begin
    int pick;
    bit full_done;
    bit over_done;
    lfde_in_t item;

    model      = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    effective  = 0;
    burst_left = 0;
    full_done  = 1'b0;
    over_done  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: disabled behavior, refresh hits, changed and unchanged pixels, restarts
    item = control(MODE_PING);
    item.frame_end = 1'b1;
    offer(item);
    offer(pixel(24'hffffff, 1'b1));          // ignored while disabled
    item = control(MODE_ENABLE);
    item.frame_end = 1'b1;
    offer(item);
    offer(pixel(24'h000000, 1'b0));          // unchanged, but on the refresh index
    offer(pixel(24'hffffff, 1'b0));          // changed
    offer(pixel(24'h000000, 1'b1));          // unchanged, marker only
    offer(pixel(24'h000000, 1'b0));
    offer(pixel(24'hffffff, 1'b0));          // refresh index has moved here
    offer(pixel(24'h123456, 1'b1));          // color word then marker
    offer(control(MODE_PING));
    offer(pixel(24'ha55ac3, 1'b1));          // one-pixel frame wraps the refresh index
    offer(control(MODE_DISABLE));
    offer(pixel(24'h808080, 1'b0));          // ignored
    offer(control(MODE_PING));
    offer(control(MODE_ENABLE));
    offer(pixel(24'h80017f, 1'b0));
    offer(pixel(24'h7ffe80, 1'b0));
    offer(control(MODE_ENABLE));             // restart mid-frame
    offer(pixel(24'hff00ff, 1'b0));
    offer(pixel(24'h00ff00, 1'b1));
    wait_drained();

    // Random traffic; the receiver holds off for a long stretch at the start
    hold_req = 1'b1;
    while (effective < ITEM_TARGET) begin
      if (!full_done && effective > 250) begin
        offer(control(MODE_ENABLE));
        send_frame(MAX_LEDS_DEF, 1'b1);
        full_done = 1'b1;
      end else if (!over_done && effective > 550) begin
        offer(control(MODE_ENABLE));
        send_frame($urandom_range(MAX_LEDS_DEF + 1, MAX_LEDS_DEF + 3), 1'b1);
        over_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (!model.enabled && pick < 80)
          offer(control(MODE_ENABLE));
        else if (pick < 5)
          offer(control(MODE_PING));
        else if (pick < 8)
          offer(control(MODE_DISABLE));
        else if (pick < 10)
          wait_drained();
        else if (pick < 14)
          offer(lfde_in_t'(27'($urandom)));
        else if (pick < 20)
          send_frame($urandom_range(1, 12), 1'b0);
        else if (pick < 30)
          send_frame($urandom_range(13, 40), 1'b1);
        else
          send_frame($urandom_range(1, 8), 1'b1);
      end
    end

    // Drain and let the pipeline settle
    in_valid <= 1'b0;
    while (model.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (model.pending_words.size() != 0) model.report("results still owed at end of run");
    if (model.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
